### rtl/core/ckh_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ckh_pkg
// shared types and codes of the two-way cuckoo set
// ----------------------------------------------------------------------------
package ckh_pkg;

	typedef enum logic [1:0] {
		OP_SEARCH = 2'd0,
		OP_INSERT = 2'd1,
		OP_REMOVE = 2'd2,
		OP_SPARE  = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_INSERTED  = 3'd0,
		ST_DUPLICATE = 3'd1,
		ST_FOUND     = 3'd2,
		ST_NOT_FOUND = 3'd3,
		ST_REMOVED   = 3'd4,
		ST_FULL      = 3'd5
	} status_t;

	typedef struct packed {
		logic [1:0]  operation;
		logic [31:0] key;
	} req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [31:0] homeless_key;
		logic [10:0] occupancy;
	} rsp_t;

	// sequencer states; the shared hash unit runs one 32x32 multiply per cycle
	typedef enum logic [4:0] {
		S_CLR,                    // clearing pass after reset
		S_IDLE,
		S_H1A, S_H1B, S_H1C,      // first hash: two multiplies then fold
		S_H2A, S_H2B,             // second hash: multiply then fold
		S_RDA, S_WTA, S_CKA,      // probe first slot
		S_RDB, S_WTB, S_CKB,      // probe second slot
		S_PRD, S_PWT, S_PCK,      // placement: read occupant
		S_EH1A, S_EH1B, S_EH1C,   // first hash of evicted key
		S_EH2A, S_EH2B,           // second hash of evicted key
		S_RESP
	} state_t;

	localparam logic [31:0] H1_MUL = 32'h045d9f3b;
	localparam logic [31:0] H2_MUL = 32'h27d4eb2d;
	localparam logic [31:0] H2_XOR = 32'd61;

endpackage
`default_nettype wire

### rtl/core/ckh_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ckh_ram
// single-port ram with registered read
// ----------------------------------------------------------------------------
module ckh_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule
`default_nettype wire

### rtl/core/cuckoo_hash_table.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cuckoo_hash_table
// two-way cuckoo set of 32-bit keys: search, insert, remove
// ----------------------------------------------------------------------------
//  channel | signals                  | beat
//  req     | req_valid/req_ready/req  | operation, key
//  rsp     | rsp_valid/rsp_ready/rsp  | status, homeless_key, occupancy
//
//  after reset a clearing pass marks every slot empty; req_ready is low
//  meanwhile
//  one request at a time; req_ready is high only while the sequencer is idle
//  search/remove/duplicate check: both hashes, a probe of the first slot and,
//  on a miss there, a probe of the second slot, then the response state
//  insert adds a placement step (read, wait, check) plus an eviction rehash
//  per displaced key, up to 2*MAX_ROUNDS steps; the sequencer returns to idle before the next request
//  the result waits in the output register until taken; a stall holds the
//  sequencer only when a new result is ready and the old one is still waiting
// ----------------------------------------------------------------------------
module cuckoo_hash_table #(
	parameter int TABLE_SIZE = 1024,
	parameter int MAX_ROUNDS = 16
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           req_valid,
	output logic                req_ready,
	input  wire ckh_pkg::req_t  req,
	output logic                rsp_valid,
	input  wire logic           rsp_ready,
	output ckh_pkg::rsp_t       rsp
);
	localparam int AW = $clog2(TABLE_SIZE);
	localparam int SW = $clog2(2 * MAX_ROUNDS + 1);
	localparam logic [SW-1:0] STEP_LAST = SW'(2 * MAX_ROUNDS - 1);
	localparam logic [AW-1:0] SLOT_LAST = AW'(TABLE_SIZE - 1);

	ckh_pkg::state_t state_q, state_d;

	// request and working registers
	logic [1:0]    op_q;
	logic [31:0]   key_q;      // key of the request
	logic [31:0]   cur_q;      // key in hand during placement
	logic [31:0]   acc_q;      // hash unit accumulator
	logic [AW-1:0] ha_q, hb_q; // slots of the request key
	logic [AW-1:0] pos_q;      // placement slot
	logic [AW-1:0] ea_q;       // first slot of evicted key
	logic [AW-1:0] clr_q;      // clearing pass address
	logic [SW-1:0] step_q;
	logic [10:0]   count_q;
	ckh_pkg::rsp_t res_q;      // result being built
	ckh_pkg::rsp_t rsp_q;
	logic          rsp_valid_q;

	// ram: occupied flag on top of the key
	logic          ram_we;
	logic [AW-1:0] ram_addr;
	logic [32:0]   ram_wdata, ram_rdata;

	ckh_ram #(.WIDTH(33), .DEPTH(TABLE_SIZE)) u_keys (
		.clk  (clk),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata(ram_wdata),
		.rdata(ram_rdata)
	);

	// shared hash unit: one multiply, one mix step per cycle
	logic [31:0] mul_a, mul_b, mul_p;
	assign mul_p = mul_a * mul_b;

	function automatic logic [31:0] fold16(input logic [31:0] v);
		return (v >> 16) ^ v;
	endfunction

	function automatic logic [31:0] h2_pre(input logic [31:0] v);
		logic [31:0] t;
		t = (v ^ ckh_pkg::H2_XOR) ^ (v >> 16);
		t = t + (t << 3);
		return t ^ (t >> 4);
	endfunction

	always_comb begin
		mul_b = ckh_pkg::H1_MUL;
		mul_a = fold16(acc_q);
		case (state_q)
			ckh_pkg::S_H2A, ckh_pkg::S_EH2A: begin
				mul_a = h2_pre(acc_q);
				mul_b = ckh_pkg::H2_MUL;
			end
			default: begin
			end
		endcase
	end

	logic [31:0]   h1_full, h2_full;
	logic [AW-1:0] h1_fin, h2_fin;
	assign h1_full = fold16(acc_q);
	assign h2_full = acc_q ^ (acc_q >> 15);
	assign h1_fin  = h1_full[AW-1:0];
	assign h2_fin  = h2_full[AW-1:0];

	logic hit;
	assign hit = ram_rdata[32] && (ram_rdata[31:0] == key_q);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ckh_pkg::S_CLR:  if (clr_q == SLOT_LAST) state_d = ckh_pkg::S_IDLE;
			ckh_pkg::S_IDLE: if (req_valid) state_d = ckh_pkg::S_H1A;
			ckh_pkg::S_H1A:  state_d = ckh_pkg::S_H1B;
			ckh_pkg::S_H1B:  state_d = ckh_pkg::S_H1C;
			ckh_pkg::S_H1C:  state_d = ckh_pkg::S_H2A;
			ckh_pkg::S_H2A:  state_d = ckh_pkg::S_H2B;
			ckh_pkg::S_H2B:  state_d = ckh_pkg::S_RDA;
			ckh_pkg::S_RDA:  state_d = ckh_pkg::S_WTA;
			ckh_pkg::S_WTA:  state_d = ckh_pkg::S_CKA;
			ckh_pkg::S_CKA:  state_d = hit ? ckh_pkg::S_RESP : ckh_pkg::S_RDB;
			ckh_pkg::S_RDB:  state_d = ckh_pkg::S_WTB;
			ckh_pkg::S_WTB:  state_d = ckh_pkg::S_CKB;
			ckh_pkg::S_CKB:
				state_d = (!hit && op_q == ckh_pkg::OP_INSERT) ? ckh_pkg::S_PRD
					: ckh_pkg::S_RESP;
			ckh_pkg::S_PRD:  state_d = ckh_pkg::S_PWT;
			ckh_pkg::S_PWT:  state_d = ckh_pkg::S_PCK;
			// empty slot or steps used up ends the insert
			ckh_pkg::S_PCK:
				state_d = (!ram_rdata[32] || step_q == STEP_LAST) ? ckh_pkg::S_RESP
					: ckh_pkg::S_EH1A;
			ckh_pkg::S_EH1A: state_d = ckh_pkg::S_EH1B;
			ckh_pkg::S_EH1B: state_d = ckh_pkg::S_EH1C;
			ckh_pkg::S_EH1C: state_d = ckh_pkg::S_EH2A;
			ckh_pkg::S_EH2A: state_d = ckh_pkg::S_EH2B;
			ckh_pkg::S_EH2B: state_d = ckh_pkg::S_PRD;
			ckh_pkg::S_RESP: if (!rsp_valid_q || rsp_ready) state_d = ckh_pkg::S_IDLE;
			default:         state_d = ckh_pkg::S_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		ram_we    = 1'b0;
		ram_addr  = pos_q;
		ram_wdata = {1'b1, cur_q};
		case (state_q)
			ckh_pkg::S_CLR: begin
				ram_we    = 1'b1;
				ram_addr  = clr_q;
				ram_wdata = '0;
			end
			ckh_pkg::S_RDA, ckh_pkg::S_WTA: ram_addr = ha_q;
			ckh_pkg::S_RDB, ckh_pkg::S_WTB: ram_addr = hb_q;
			// a removed key only drops its occupied flag
			ckh_pkg::S_CKA: begin
				ram_addr  = ha_q;
				ram_we    = hit && op_q == ckh_pkg::OP_REMOVE;
				ram_wdata = {1'b0, key_q};
			end
			ckh_pkg::S_CKB: begin
				ram_addr  = hb_q;
				ram_we    = hit && op_q == ckh_pkg::OP_REMOVE;
				ram_wdata = {1'b0, key_q};
			end
			// occupant is on ram_rdata; overwrite with key in hand
			ckh_pkg::S_PCK: ram_we = 1'b1;
			default: begin
			end
		endcase
	end

	assign req_ready = (state_q == ckh_pkg::S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ckh_pkg::S_CLR;
			clr_q       <= '0;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ckh_pkg::S_RESP && (!rsp_valid_q || rsp_ready))
				rsp_valid_q <= 1'b1;
			else if (rsp_ready)
				rsp_valid_q <= 1'b0;
			case (state_q)
				ckh_pkg::S_CLR: clr_q <= clr_q + AW'(1);
				ckh_pkg::S_CKA, ckh_pkg::S_CKB:
					if (hit && op_q == ckh_pkg::OP_REMOVE) count_q <= count_q - 11'd1;
				ckh_pkg::S_PCK:
					if (!ram_rdata[32]) count_q <= count_q + 11'd1;
				default: begin
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ckh_pkg::S_IDLE: begin
				op_q  <= req.operation;
				key_q <= req.key;
				acc_q <= req.key;
				step_q <= '0;
			end
			ckh_pkg::S_H1A, ckh_pkg::S_H1B, ckh_pkg::S_EH1A, ckh_pkg::S_EH1B:
				acc_q <= mul_p;
			ckh_pkg::S_H1C: begin
				ha_q  <= h1_fin;
				pos_q <= h1_fin;
				acc_q <= key_q;
			end
			ckh_pkg::S_H2A, ckh_pkg::S_EH2A: acc_q <= mul_p;
			ckh_pkg::S_H2B: begin
				hb_q  <= h2_fin;
				cur_q <= key_q;
			end
			ckh_pkg::S_EH1C: begin
				ea_q  <= h1_fin;
				acc_q <= cur_q;
			end
			// displaced key goes to its other slot
			ckh_pkg::S_EH2B: pos_q <= (ea_q == pos_q) ? h2_fin : ea_q;
			ckh_pkg::S_PCK: begin
				cur_q  <= ram_rdata[31:0];
				acc_q  <= ram_rdata[31:0];
				step_q <= step_q + SW'(1);
			end
			default: begin
			end
		endcase
	end

	// result build and hand-off to the output register
	always_ff @(posedge clk) begin
		case (state_q)
			ckh_pkg::S_CKA: begin
				res_q.homeless_key <= '0;
				res_q.occupancy    <= (hit && op_q == ckh_pkg::OP_REMOVE)
					? count_q - 11'd1 : count_q;
				case (op_q)
					ckh_pkg::OP_INSERT: res_q.status <= ckh_pkg::ST_DUPLICATE;
					ckh_pkg::OP_REMOVE: res_q.status <= ckh_pkg::ST_REMOVED;
					default:            res_q.status <= ckh_pkg::ST_FOUND;
				endcase
			end
			ckh_pkg::S_CKB: begin
				res_q.homeless_key <= '0;
				res_q.occupancy    <= (hit && op_q == ckh_pkg::OP_REMOVE)
					? count_q - 11'd1 : count_q;
				case (op_q)
					ckh_pkg::OP_INSERT: res_q.status <= ckh_pkg::ST_DUPLICATE;
					ckh_pkg::OP_REMOVE:
						res_q.status <= hit ? ckh_pkg::ST_REMOVED : ckh_pkg::ST_NOT_FOUND;
					default:
						res_q.status <= hit ? ckh_pkg::ST_FOUND : ckh_pkg::ST_NOT_FOUND;
				endcase
			end
			ckh_pkg::S_PCK:
				if (!ram_rdata[32]) begin
					res_q.status       <= ckh_pkg::ST_INSERTED;
					res_q.homeless_key <= '0;
					res_q.occupancy    <= count_q + 11'd1;
				end else if (step_q == STEP_LAST) begin
					res_q.status       <= ckh_pkg::ST_FULL;
					res_q.homeless_key <= ram_rdata[31:0];
					res_q.occupancy    <= count_q;
				end
			ckh_pkg::S_RESP:
				if (!rsp_valid_q || rsp_ready) rsp_q <= res_q;
			default: begin
			end
		endcase
	end

`ifndef SYNTHESIS
	// no request is taken while a response is being produced
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ckh_pkg::S_IDLE) |-> !req_ready)
		else $error("req_ready high while busy");

	// count moves by at most one per cycle
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == $past(count_q)) || (count_q == $past(count_q) + 11'd1)
		|| (count_q == $past(count_q) - 11'd1))
		else $error("occupancy jumped");

	// homeless key is zero unless the table is full
	a_full_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.status != ckh_pkg::ST_FULL) |-> (rsp.homeless_key == 32'd0))
		else $error("homeless key without full status");
`endif

endmodule
`default_nettype wire
